// File: hdl/ndst_pkg.sv
package ndst_pkg;
   localparam int NODES = 64;
   localparam int IDX_W = $clog2(NODES);
   localparam int CNT_W = $clog2(NODES + 1);

   localparam logic [2:0] FUNC_REG    = 3'd0;
   localparam logic [2:0] FUNC_DATA   = 3'd1;
   localparam logic [2:0] FUNC_TICK   = 3'd2;
   localparam logic [2:0] FUNC_REMOVE = 3'd3;
   localparam logic [2:0] FUNC_QUERY  = 3'd4;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_UPDATED  = 2'd3;

   localparam logic [1:0] ADDR_MISS_LIMIT = 2'd0;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] node_addr;
      logic [15:0] seq_no;
      logic        via_relay;
      logic        node_kind;
      logic        link_up;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] rx_count;
      logic [15:0] direct_count;
      logic [15:0] main_count;
      logic [15:0] newest_seq;
      logic [7:0]  misses;
      logic        is_up;
   } rsp_type;

   typedef struct packed {
      logic [15:0] addr;
      logic        kind;
      logic        up;
      logic [15:0] rx;
      logic [15:0] direct;
      logic [15:0] main;
      logic [15:0] latest;
      logic [15:0] prev;
      logic [7:0]  miss;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_EVAL, S_TICK_RD, S_TICK_EV, S_WRITE, S_OUT
   } state_type;
endpackage

// File: hdl/ndst_if.sv
interface ndst_req_if;
   import ndst_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ndst_rsp_if;
   import ndst_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/node_delivery_stats_table_top.sv
// Node delivery statistics table. Items are taken one at a time. Register,
// data arrival, remove and query sweep the entry memory once, one slot per
// cycle, over its single read port to find the address and the lowest free
// slot. On a hit they then do one read-modify-write of that slot, and an
// insert writes the new entry; when the address is not found or the table
// is full, nothing is written. The tick reads and writes back every slot in
// turn, going through S_TICK_RD and then S_TICK_EV for each slot. The result
// can wait any time to be taken. After the result leaves, the block goes
// back to idle and then takes the next item. Valid marks are flip-flops
// cleared by reset; no clearing pass is needed.
module node_delivery_stats_table_top (
   input  logic        clock,
   input  logic        reset,
   ndst_req_if.sink    req,
   ndst_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ndst_pkg::*;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   rsp_type          rsp_ff, rsp_in;
   logic [7:0]       limit_ff;
   logic [NODES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             hit_ff, hit_in, free_ok_ff, free_ok_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   entry_type        ent_ff, ent_in;

   logic             we;
   logic [IDX_W-1:0] waddr, raddr;
   entry_type        wdata, rdata;

   ndst_ram #(.WIDTH(ENTRY_W), .DEPTH(NODES)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ADDR_MISS_LIMIT[0]) ? {24'd0, limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 8'd3;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == ADDR_MISS_LIMIT[0]) begin
         limit_ff <= csr_pwdata[7:0];
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      cnt_ff <= cnt_in;
      rd_idx_ff <= rd_idx_in;
      hit_ff <= hit_in;
      free_ok_ff <= free_ok_in;
      hit_idx_ff <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      ent_ff <= ent_in;
   end

   function automatic rsp_type show(logic [1:0] st, entry_type e);
      rsp_type r;
      r.status = st;
      r.rx_count = e.rx;
      r.direct_count = e.direct;
      r.main_count = e.main;
      r.newest_seq = e.latest;
      r.misses = e.miss;
      r.is_up = e.up;
      return r;
   endfunction

   always_comb begin
      entry_type e;
      state_in = state_ff;
      valid_in = valid_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      cnt_in = cnt_ff;
      rd_idx_in = rd_idx_ff;
      hit_in = hit_ff;
      free_ok_in = free_ok_ff;
      hit_idx_in = hit_idx_ff;
      free_idx_in = free_idx_ff;
      ent_in = ent_ff;
      we = 1'b0;
      waddr = hit_idx_ff;
      wdata = ent_ff;
      raddr = cnt_ff[IDX_W-1:0];
      e = rdata;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            hit_in = 1'b0;
            free_ok_in = 1'b0;
            if (req.valid) begin
               req_in = req.payload;
               rd_idx_in = '0;
               if (req.payload.func == FUNC_TICK) begin
                  state_in = S_TICK_RD;
               end else if (req.payload.func inside {FUNC_REG, FUNC_DATA, FUNC_REMOVE,
                                                      FUNC_QUERY}) begin
                  state_in = S_SCAN;
               end else begin
                  rsp_in = '0;
                  state_in = S_OUT;
               end
            end
         end
         S_SCAN: begin
            // rdata holds slot rd_idx_ff when cnt_ff > 0
            if (cnt_ff != '0) begin
               if (valid_ff[rd_idx_ff] && rdata.addr == req_ff.node_addr && !hit_ff) begin
                  hit_in = 1'b1;
                  hit_idx_in = rd_idx_ff;
               end
               if (!valid_ff[rd_idx_ff] && !free_ok_ff) begin
                  free_ok_in = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
            end
            rd_idx_in = cnt_ff[IDX_W-1:0];
            if (cnt_ff == CNT_W'(NODES)) begin
               state_in = S_EVAL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_EVAL: begin
            raddr = hit_idx_ff;
            if (!hit_ff) begin
               rsp_in = '0;
               rsp_in.status = ST_NOTFOUND;
               if (req_ff.func == FUNC_REG) begin
                  if (free_ok_ff) begin
                     ent_in = '0;
                     ent_in.addr = req_ff.node_addr;
                     ent_in.kind = req_ff.node_kind;
                     ent_in.up = req_ff.link_up;
                     hit_idx_in = free_idx_ff;
                     rsp_in = show(ST_DONE, ent_in);
                     valid_in[free_idx_ff] = 1'b1;
                     state_in = S_WRITE;
                  end else begin
                     rsp_in.status = ST_FULL;
                     state_in = S_OUT;
                  end
               end else begin
                  state_in = S_OUT;
               end
            end else begin
               state_in = S_TICK_EV; // the hit slot is read here and evaluated in S_TICK_EV
               cnt_in = '0;
            end
         end
         S_TICK_EV: begin
            if (req_ff.func != FUNC_TICK) begin
               case (req_ff.func)
                  FUNC_REG: begin
                     e.kind = req_ff.node_kind;
                     e.up = req_ff.link_up;
                     rsp_in = show(ST_UPDATED, e);
                  end
                  FUNC_DATA: begin
                     if (e.latest < req_ff.seq_no) begin
                        e.rx = e.rx + 16'd1;
                        e.latest = req_ff.seq_no;
                        e.miss = '0;
                     end else if (e.latest > req_ff.seq_no) begin
                        e.rx = 16'd1;
                        e.main = '0;
                        e.direct = '0;
                        e.latest = req_ff.seq_no;
                        e.miss = '0;
                        e.prev = req_ff.seq_no - 16'd1;
                     end
                     if (!e.kind) begin
                        if (!req_ff.via_relay) begin
                           e.main = e.main + 16'd1;
                           e.direct = e.direct + 16'd1;
                        end
                     end else if (req_ff.via_relay) begin
                        e.main = e.main + 16'd1;
                     end else begin
                        e.direct = e.direct + 16'd1;
                     end
                     rsp_in = show(ST_DONE, e);
                  end
                  FUNC_REMOVE: begin
                     rsp_in = show(ST_DONE, e);
                     valid_in[hit_idx_ff] = 1'b0;
                  end
                  default: rsp_in = show(ST_DONE, e);
               endcase
               ent_in = e;
               state_in = S_WRITE;
            end else begin
               // tick sweep: rdata is slot rd_idx_ff
               if (valid_ff[rd_idx_ff] && e.up) begin
                  if (e.prev == e.latest) begin
                     if (e.miss < limit_ff) e.miss = e.miss + 8'd1;
                  end else begin
                     e.miss = '0;
                  end
                  e.prev = e.latest;
               end
               we = 1'b1;
               waddr = rd_idx_ff;
               wdata = e;
               if (cnt_ff == CNT_W'(NODES - 1)) begin
                  rsp_in = '0;
                  state_in = S_OUT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  state_in = S_TICK_RD;
               end
            end
         end
         S_TICK_RD: begin
            rd_idx_in = cnt_ff[IDX_W-1:0];
            state_in = S_TICK_EV;
         end
         S_WRITE: begin
            we = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// File: hdl/ndst_ram.sv
module ndst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

// File: tb/sv/node_delivery_stats_table_top_tb.sv
`timescale 1ns / 100ps

module node_delivery_stats_table_top_tb;
   import ndst_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ndst_req_if req_if ();
   ndst_rsp_if rsp_if ();

   node_delivery_stats_table_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if.sink),
      .rsp         (rsp_if.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow node table
   logic [7:0]  lim;
   logic        tv [NODES];
   entry_type   tbl [NODES];

   req_type     pending_items [$];
   rsp_type     expected_rsps [$];
   int          mismatches;
   int          issued;
   logic        feeding;
   logic        req_acc;
   int          req_gap;
   int          rsp_gap;
   logic [15:0] addr_pool [8];

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic int find_node(logic [15:0] a);
      for (int i = 0; i < NODES; i++)
         if (tv[i] && tbl[i].addr == a) return i;
      return -1;
   endfunction

   function automatic rsp_type show_entry(logic [1:0] st, int s);
      rsp_type r;
      r = '0;
      r.status = st;
      if (s >= 0) begin
         r.rx_count = tbl[s].rx;
         r.direct_count = tbl[s].direct;
         r.main_count = tbl[s].main;
         r.newest_seq = tbl[s].latest;
         r.misses = tbl[s].miss;
         r.is_up = tbl[s].up;
      end
      return r;
   endfunction

   function automatic rsp_type apply_item(req_type it);
      int s;
      int f;
      rsp_type r;
      r = '0;
      s = find_node(it.node_addr);
      case (it.func)
         FUNC_REG: begin
            if (s >= 0) begin
               tbl[s].kind = it.node_kind;
               tbl[s].up = it.link_up;
               r = show_entry(ST_UPDATED, s);
            end else begin
               f = -1;
               for (int i = NODES - 1; i >= 0; i--)
                  if (!tv[i]) f = i;
               if (f < 0) begin
                  r = show_entry(ST_FULL, -1);
               end else begin
                  tv[f] = 1'b1;
                  tbl[f] = '0;
                  tbl[f].addr = it.node_addr;
                  tbl[f].kind = it.node_kind;
                  tbl[f].up = it.link_up;
                  r = show_entry(ST_DONE, f);
               end
            end
         end
         FUNC_DATA: begin
            if (s < 0) begin
               r = show_entry(ST_NOTFOUND, -1);
            end else begin
               if (tbl[s].latest < it.seq_no) begin
                  tbl[s].rx++;
                  tbl[s].latest = it.seq_no;
                  tbl[s].miss = '0;
               end else if (tbl[s].latest > it.seq_no) begin
                  tbl[s].rx = 16'd1;
                  tbl[s].main = '0;
                  tbl[s].direct = '0;
                  tbl[s].latest = it.seq_no;
                  tbl[s].miss = '0;
                  tbl[s].prev = it.seq_no - 16'd1;
               end
               if (!tbl[s].kind) begin
                  if (!it.via_relay) begin
                     tbl[s].main++;
                     tbl[s].direct++;
                  end
               end else if (it.via_relay) begin
                  tbl[s].main++;
               end else begin
                  tbl[s].direct++;
               end
               r = show_entry(ST_DONE, s);
            end
         end
         FUNC_TICK: begin
            for (int i = 0; i < NODES; i++) begin
               if (tv[i] && tbl[i].up) begin
                  if (tbl[i].prev == tbl[i].latest) begin
                     if (tbl[i].miss < lim) tbl[i].miss++;
                  end else begin
                     tbl[i].miss = '0;
                  end
                  tbl[i].prev = tbl[i].latest;
               end
            end
         end
         FUNC_REMOVE: begin
            if (s < 0) begin
               r = show_entry(ST_NOTFOUND, -1);
            end else begin
               r = show_entry(ST_DONE, s);
               tv[s] = 1'b0;
            end
         end
         FUNC_QUERY: begin
            r = show_entry(s < 0 ? ST_NOTFOUND : ST_DONE, s);
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_acc) begin
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_if.valid <= 1'b0;
      end else if (feeding && pending_items.size() > 0) begin
         req_if.valid <= 1'b1;
         req_if.payload <= pending_items.pop_front();
         req_gap <= ($urandom_range(0, 3) == 0) ?
                    (($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                                 : $urandom_range(0, 4)) : 0;
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0)
            rsp_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                                   : $urandom_range(1, 4);
      end
   end

   // predictor runs on acceptance
   always @(posedge clock) begin
      req_acc <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         expected_rsps.push_back(apply_item(req_if.payload));
         issued++;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h", rsp_if.payload);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_if.payload.status !== e.status ||
                rsp_if.payload.rx_count !== e.rx_count ||
                rsp_if.payload.direct_count !== e.direct_count ||
                rsp_if.payload.main_count !== e.main_count ||
                rsp_if.payload.newest_seq !== e.newest_seq ||
                rsp_if.payload.misses !== e.misses ||
                rsp_if.payload.is_up !== e.is_up) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", e, rsp_if.payload);
            end
         end
      end
   end

   task automatic write_limit(logic [7:0] v);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {ADDR_MISS_LIMIT, 1'b0} << 1;
      csr_pwdata <= {24'd0, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      lim = v;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic add_item(logic [2:0] f, logic [15:0] a, logic [15:0] sq,
                           logic r, logic k, logic u);
      req_type it;
      it.func = f;
      it.node_addr = a;
      it.seq_no = sq;
      it.via_relay = r;
      it.node_kind = k;
      it.link_up = u;
      pending_items.push_back(it);
   endtask

   task automatic drain;
      int w;
      w = 0;
      while (pending_items.size() > 0 || req_if.valid || expected_rsps.size() > 0)
         @(posedge clock);
      while (w < 100) begin
         @(posedge clock);
         w++;
      end
   endtask

   function automatic logic [15:0] pick_addr();
      if ($urandom_range(0, 9) == 0) return 16'($urandom());
      return addr_pool[$urandom_range(0, 7)];
   endfunction

   task automatic random_phase(int n);
      int c;
      logic [15:0] a;
      for (int i = 0; i < n; i++) begin
         c = $urandom_range(0, 99);
         a = pick_addr();
         if (c < 15)
            add_item(FUNC_REG, a, 16'($urandom()), 1'($urandom()), 1'($urandom()),
                     1'($urandom()));
         else if (c < 60)
            add_item(FUNC_DATA, a, ($urandom_range(0, 3) == 0) ? 16'($urandom())
                     : 16'($urandom_range(0, 40)), 1'($urandom()), 1'($urandom()),
                     1'($urandom()));
         else if (c < 78)
            add_item(FUNC_TICK, a, 16'($urandom()), 1'($urandom()), 1'($urandom()),
                     1'($urandom()));
         else if (c < 86)
            add_item(FUNC_REMOVE, a, 16'($urandom()), 1'($urandom()), 1'($urandom()),
                     1'($urandom()));
         else if (c < 97)
            add_item(FUNC_QUERY, a, 16'($urandom()), 1'($urandom()), 1'($urandom()),
                     1'($urandom()));
         else
            add_item(3'($urandom_range(5, 7)), a, 16'($urandom()), 1'($urandom()),
                     1'($urandom()), 1'($urandom()));
      end
   endtask

   initial begin
      reset = 1'b1;
      feeding = 1'b0;
      req_acc = 1'b0;
      req_gap = 0;
      rsp_gap = 0;
      mismatches = 0;
      issued = 0;
      lim = 8'd3;
      for (int i = 0; i < NODES; i++) begin
         tv[i] = 1'b0;
         tbl[i] = '0;
      end
      for (int i = 0; i < 8; i++) addr_pool[i] = 16'($urandom());
      addr_pool[0] = 16'h0000;
      addr_pool[1] = 16'hFFFF;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed
      add_item(FUNC_QUERY, 16'h0000, 16'd0, 1'b0, 1'b0, 1'b0);
      add_item(FUNC_DATA, 16'hFFFF, 16'd5, 1'b0, 1'b0, 1'b0);
      add_item(FUNC_REMOVE, 16'h1234, 16'd0, 1'b0, 1'b0, 1'b0);
      add_item(FUNC_REG, 16'h0000, 16'd0, 1'b0, 1'b0, 1'b1);
      add_item(FUNC_REG, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
      add_item(FUNC_DATA, 16'h0000, 16'd10, 1'b0, 1'b0, 1'b0);
      add_item(FUNC_DATA, 16'h0000, 16'd10, 1'b1, 1'b0, 1'b0);
      add_item(FUNC_DATA, 16'h0000, 16'd4, 1'b0, 1'b0, 1'b0);
      add_item(FUNC_DATA, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
      add_item(FUNC_DATA, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      add_item(FUNC_REG, 16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b0);
      add_item(FUNC_QUERY, 16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b0);
      add_item(3'd5, 16'h0000, 16'd0, 1'b0, 1'b0, 1'b0);
      add_item(3'd7, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
      add_item(FUNC_REMOVE, 16'h0000, 16'd0, 1'b0, 1'b0, 1'b0);
      add_item(FUNC_QUERY, 16'h0000, 16'd0, 1'b0, 1'b0, 1'b0);
      feeding = 1'b1;
      drain();

      // fill the table to overflow
      for (int i = 0; i < NODES + 2; i++)
         add_item(FUNC_REG, 16'(16'h8000 + i), 16'd0, 1'b0, i[0], 1'b1);
      add_item(FUNC_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
      add_item(FUNC_REMOVE, 16'h8005, 16'd0, 1'b0, 1'b0, 1'b0);
      add_item(FUNC_REG, 16'h4444, 16'd0, 1'b0, 1'b0, 1'b1);
      drain();
      for (int i = 0; i < NODES; i++)
         add_item(FUNC_REMOVE, 16'(16'h8000 + i), 16'd0, 1'b0, 1'b0, 1'b0);
      drain();

      write_limit(8'd0);
      random_phase(150);
      drain();
      write_limit(8'd255);
      random_phase(150);
      drain();
      write_limit(8'd1);
      random_phase(150);
      drain();
      write_limit(8'($urandom_range(2, 254)));
      random_phase(150);
      drain();

      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #40ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
